>>> sv/uwd_pkg.sv
// uwd_pkg: shared types and constants for the unsigned divider pipeline
// no dependencies; used by uwd_stage and unsigned_divide_with_remainder
package uwd_pkg;

    // port width of every operand and result field
    localparam int FIELD_W        = 64;
    // default operand width, handed to the top level parameter
    localparam int DATA_WIDTH_DEF = 64;

    // control that travels with each transaction down the pipeline
    typedef struct packed {
        logic valid;
        logic dz;
    } t_ctl;

endpackage

>>> sv/uwd_stage.sv
// uwd_stage: one restoring division step, produces one quotient bit per cycle
// depends on uwd_pkg for the control struct
module uwd_stage #(
    parameter int WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  uwd_pkg::t_ctl     i_ctl,
    input  logic [WIDTH-1:0]  i_rem,
    input  logic [WIDTH-1:0]  i_nq,
    input  logic [WIDTH-1:0]  i_den,
    output uwd_pkg::t_ctl     o_ctl,
    output logic [WIDTH-1:0]  o_rem,
    output logic [WIDTH-1:0]  o_nq,
    output logic [WIDTH-1:0]  o_den
);
    import uwd_pkg::*;

    logic [WIDTH:0]   shifted;
    logic [WIDTH+1:0] diff;
    logic             fits;

    t_ctl             r_ctl;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_nq;
    logic [WIDTH-1:0] r_den;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] n_nq;

    // partial remainder takes the next numerator bit from the top of nq
    always_comb begin
        shifted = {i_rem, i_nq[WIDTH-1]};
        diff    = {1'b0, shifted} - {2'b00, i_den};
        fits    = ~diff[WIDTH+1];
        n_rem   = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        // numerator bits shift out at the top, quotient bits shift in at the bottom
        n_nq    = {i_nq[WIDTH-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_nq  <= n_nq;
        r_den <= i_den;
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_nq  = r_nq;
    assign o_den = r_den;

endmodule

>>> sv/unsigned_divide_with_remainder.sv
// unsigned_divide_with_remainder: pipelined restoring unsigned divider
// depends on uwd_pkg and uwd_stage
//
// usage:
//   present i_numerator and i_denominator with start high; the transaction is
//   taken at the rising edge where start is high and busy is low. busy is low
//   whenever the block is out of reset, so a new transaction can enter in
//   every cycle.
//   operands are cut to DATA_WIDTH bits (at most 64); each pipeline stage
//   resolves one quotient bit with one compare and subtract, and the
//   throughput is one transaction per cycle.
//   the result shows on o_quotient, o_remainder and o_divide_by_zero for
//   exactly one cycle with o_strobe high. a zero denominator sets
//   o_divide_by_zero, returns quotient 0 and the numerator as remainder.
//   the receiver cannot stall; results leave in the order they entered.
//   synchronous active-low reset drops every transaction in flight; busy is
//   high while reset is asserted.
module unsigned_divide_with_remainder #(
    parameter int DATA_WIDTH = uwd_pkg::DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [uwd_pkg::FIELD_W-1:0] i_numerator,
    input  logic [uwd_pkg::FIELD_W-1:0] i_denominator,
    output logic                        o_strobe,
    output logic [uwd_pkg::FIELD_W-1:0] o_quotient,
    output logic [uwd_pkg::FIELD_W-1:0] o_remainder,
    output logic                        o_divide_by_zero
);
    import uwd_pkg::*;

    // working width, the fields carry no more than FIELD_W bits
    localparam int W = (DATA_WIDTH > FIELD_W) ? FIELD_W : DATA_WIDTH;

    t_ctl         ctl [W+1];
    logic [W-1:0] rem [W+1];
    logic [W-1:0] nq  [W+1];
    logic [W-1:0] den [W+1];

    logic [W-1:0] num_in;
    logic [W-1:0] den_in;

    assign busy   = ~i_rst_n;
    assign num_in = i_numerator[W-1:0];
    assign den_in = i_denominator[W-1:0];

    // control enters as {valid, dz}
    assign ctl[0] = {start & ~busy, den_in == '0};
    assign rem[0] = '0;
    assign nq[0]  = num_in;
    assign den[0] = den_in;

    for (genvar g = 0; g < W; g++) begin : g_stage
        uwd_stage #(
            .WIDTH (W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[g]),
            .i_rem   (rem[g]),
            .i_nq    (nq[g]),
            .i_den   (den[g]),
            .o_ctl   (ctl[g+1]),
            .o_rem   (rem[g+1]),
            .o_nq    (nq[g+1]),
            .o_den   (den[g+1])
        );
    end

    // with a zero divisor every step subtracts nothing, so the remainder is
    // already the numerator and only the quotient needs forcing
    assign o_strobe         = ctl[W].valid;
    assign o_divide_by_zero = ctl[W].dz;
    assign o_quotient       = ctl[W].dz ? '0 : FIELD_W'(nq[W]);
    assign o_remainder      = FIELD_W'(rem[W]);

    a_strobe_follows_start: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, W)
    ) else $error("result without a transaction W cycles earlier");

    a_dz_matches_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_divide_by_zero == ($past(den_in, W) == '0))
    ) else $error("divide-by-zero flag does not match the accepted divisor");

    a_dz_quotient_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_divide_by_zero) |-> (o_quotient == '0)
    ) else $error("nonzero quotient on divide by zero");

    a_rem_below_den: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_divide_by_zero) |-> (o_remainder < FIELD_W'($past(den_in, W)))
    ) else $error("remainder not below divisor");

endmodule

>>> verif/tb_unsigned_divide_with_remainder.sv
// tb_unsigned_divide_with_remainder: self-checking bench for the pipelined unsigned divider
// depends on uwd_pkg and unsigned_divide_with_remainder; drives operand pairs with random gaps
// and checks quotient, remainder and divide-by-zero flag against native integer division
module tb_unsigned_divide_with_remainder;

    import uwd_pkg::*;

    localparam int DW          = DATA_WIDTH_DEF;
    localparam int PIPE_DEPTH  = (DW > FIELD_W) ? FIELD_W : DW;
    localparam int RAND_COUNT  = 1500;
    localparam int CALM_TAIL   = 200;

    typedef logic [FIELD_W-1:0] word_t;

    typedef struct {
        word_t num;
        word_t den;
    } operand_pair_t;

    typedef struct {
        word_t quo;
        word_t rem;
        logic  dz;
    } division_t;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    word_t i_numerator = '0;
    word_t i_denominator = '0;
    logic  o_strobe;
    word_t o_quotient;
    word_t o_remainder;
    logic  o_divide_by_zero;

    operand_pair_t pending_ops[$];
    division_t     awaited_results[$];
    int            idle_left = 0;
    int            fail_count = 0;
    int            issued_count = 0;
    int            zero_div_count = 0;
    int            checked_count = 0;

    unsigned_divide_with_remainder #(.DATA_WIDTH(DW)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_numerator     (i_numerator),
        .i_denominator   (i_denominator),
        .o_strobe        (o_strobe),
        .o_quotient      (o_quotient),
        .o_remainder     (o_remainder),
        .o_divide_by_zero(o_divide_by_zero)
    );

    always #2 i_clk = ~i_clk;

    function automatic word_t width_mask();
        if (PIPE_DEPTH >= FIELD_W) begin
            return '1;
        end
        return (word_t'(1) << PIPE_DEPTH) - 1;
    endfunction

    function automatic division_t predict_division(word_t num_in, word_t den_in);
        division_t res;
        word_t     n;
        word_t     d;
        n = num_in & width_mask();
        d = den_in & width_mask();
        if (d == '0) begin
            res.quo = '0;
            res.rem = n;
            res.dz  = 1'b1;
        end else begin
            res.quo = n / d;
            res.rem = n % d;
            res.dz  = 1'b0;
        end
        return res;
    endfunction

    // random value of random significant length, so small and large magnitudes both show up
    function automatic word_t rand_word();
        word_t v;
        v = {$urandom, $urandom};
        return v >> $urandom_range(0, FIELD_W - 1);
    endfunction

    function automatic word_t full_word();
        return {$urandom, $urandom};
    endfunction

    task automatic add_pair(word_t n, word_t d);
        operand_pair_t p;
        p.num = n;
        p.den = d;
        pending_ops.push_back(p);
    endtask

    // driver: one transaction offered at a time, held until taken
    always @(posedge i_clk) begin
        operand_pair_t nxt;
        logic          taken;
        taken = start && !busy;
        if (taken) begin
            awaited_results.push_back(predict_division(i_numerator, i_denominator));
            issued_count++;
            if ((i_denominator & width_mask()) == '0) begin
                zero_div_count++;
            end
        end
        if (start && !taken) begin
            // hold the offered transaction
        end else if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
        end else if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            idle_left = $urandom_range(1, 10) - 1;
            start <= 1'b0;
        end else if (pending_ops.size() > 0) begin
            nxt = pending_ops.pop_front();
            i_numerator   <= nxt.num;
            i_denominator <= nxt.den;
            start         <= 1'b1;
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        division_t want;
        if (o_strobe === 1'b1) begin
            if (awaited_results.size() == 0) begin
                $error("result with no transaction pending: quotient %h remainder %h dz %b",
                       o_quotient, o_remainder, o_divide_by_zero);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                checked_count++;
                if (o_quotient !== want.quo) begin
                    $error("quotient: expected %h, got %h", want.quo, o_quotient);
                    fail_count++;
                end
                if (o_remainder !== want.rem) begin
                    $error("remainder: expected %h, got %h", want.rem, o_remainder);
                    fail_count++;
                end
                if (o_divide_by_zero !== want.dz) begin
                    $error("divide_by_zero: expected %b, got %b", want.dz, o_divide_by_zero);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        word_t max_w;
        word_t msb;
        word_t n;
        word_t d;
        max_w = '1;
        msb   = word_t'(1) << (FIELD_W - 1);

        // edge cases: zero divisor, divisor above numerator, extremes, top-bit operands
        add_pair('0, '0);
        add_pair(max_w, '0);
        add_pair(64'd1, '0);
        add_pair('0, 64'd1);
        add_pair('0, max_w);
        add_pair(max_w, max_w);
        add_pair(max_w, 64'd1);
        add_pair(max_w, 64'd2);
        add_pair(64'd1, max_w);
        add_pair(max_w - 1, max_w);
        add_pair(msb, msb);
        add_pair(msb, 64'd3);
        add_pair(max_w, msb);
        add_pair(max_w, msb + 1);
        add_pair(msb - 1, msb);
        add_pair(64'd12345, 64'd12345);
        add_pair(64'd100, 64'd7);
        add_pair(64'd7, 64'd100);
        add_pair(max_w, 64'hFFFF_FFFF);
        add_pair(64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);
        add_pair(64'h5A5A_5A5A_5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5);
        add_pair(64'd5, 64'd1);

        for (int k = 0; k < RAND_COUNT; k++) begin
            case ($urandom_range(0, 9))
                0: begin
                    n = full_word();
                    d = '0;
                end
                1: begin
                    // divisor above numerator
                    n = rand_word();
                    d = n + 1 + rand_word();
                    if (d <= n) d = max_w;
                end
                2: begin
                    // exact multiple plus a small offset
                    d = rand_word() | 64'd1;
                    n = d * (rand_word() >> $urandom_range(0, 48)) + $urandom_range(0, 3);
                end
                3, 4: begin
                    n = full_word();
                    d = word_t'($urandom_range(1, 255));
                end
                5: begin
                    n = full_word();
                    d = msb | full_word();
                end
                6: begin
                    n = rand_word();
                    d = rand_word();
                end
                default: begin
                    n = full_word();
                    d = full_word();
                end
            endcase
            add_pair(n, d);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() > 0 || start || awaited_results.size() > 0) begin
            @(posedge i_clk);
        end
        // let any stray strobe show before closing
        repeat (PIPE_DEPTH + 16) @(posedge i_clk);

        $display("divisions checked: %0d of %0d issued, %0d with a zero divisor",
                 checked_count, issued_count, zero_div_count);
        if (fail_count == 0) begin
            $display("unsigned_divide_with_remainder verification clean");
        end else begin
            $display("unsigned_divide_with_remainder verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d transactions outstanding", awaited_results.size());
        $display("unsigned_divide_with_remainder verification failed");
        $finish;
    end

endmodule
